/* rtl/cau_pkg.sv */
// Shared types, codes and saturation helpers for the complex arithmetic unit.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package cau_pkg;

    typedef enum logic [2:0] {
        REQ_ADD  = 3'd0,
        REQ_SUB  = 3'd1,
        REQ_MUL  = 3'd2,
        REQ_DIV  = 3'd3,
        REQ_NEG  = 3'd4,
        REQ_CONJ = 3'd5,
        REQ_POW  = 3'd6
    } t_req;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DZ  = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    // product tags: x and y are the two complex operands of the product engine
    localparam logic [2:0] PR_RR  = 3'd0;
    localparam logic [2:0] PR_II  = 3'd1;
    localparam logic [2:0] PR_RI  = 3'd2;
    localparam logic [2:0] PR_IR  = 3'd3;
    localparam logic [2:0] PR_YRR = 3'd4;
    localparam logic [2:0] PR_YII = 3'd5;

    localparam logic [2:0] CMUL_LAST = PR_IR;
    localparam logic [2:0] CDIV_LAST = PR_YII;

    typedef enum logic [3:0] {
        OP_NOP, OP_LOAD, OP_SIMPLE, OP_PROD, OP_MFIN, OP_DZERO,
        OP_DINIT, OP_DSTEP, OP_DFIN, OP_KSHIFT, OP_OUT
    } t_op;

    typedef enum logic [1:0] {XS_A, XS_RES, XS_ONE} t_xsel;
    typedef enum logic [1:0] {YS_A, YS_B, YS_RES} t_ysel;

    typedef struct packed {
        t_xsel xsel;
        t_ysel ysel;
        logic  conj;
        logic  dest_a;
    } t_mode;

    localparam t_mode M_MUL   = '{xsel: XS_A,   ysel: YS_B,   conj: 1'b0, dest_a: 1'b0};
    localparam t_mode M_DIV   = '{xsel: XS_A,   ysel: YS_B,   conj: 1'b1, dest_a: 1'b0};
    localparam t_mode M_RSTEP = '{xsel: XS_RES, ysel: YS_A,   conj: 1'b0, dest_a: 1'b0};
    localparam t_mode M_SQ    = '{xsel: XS_A,   ysel: YS_A,   conj: 1'b0, dest_a: 1'b1};
    localparam t_mode M_RECIP = '{xsel: XS_ONE, ysel: YS_RES, conj: 1'b1, dest_a: 1'b0};

    typedef struct packed {
        t_op        op;
        logic [2:0] step;
        t_mode      mode;
        logic       part_im;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic k_zero;
        logic k_lsb;
        logic k_one;
        logic k_neg;
        logic d_zero;
        logic out_free;
    } t_stat;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_MUL, S_MWAIT, S_MFIN, S_DCHK, S_DINIT,
        S_DRUN, S_DFIN, S_PWTEST, S_PWSQ, S_FIN
    } t_state;

    // {overflow, value} for a sign and magnitude
    function automatic logic [32:0] sat_mag(input logic neg, input logic [63:0] q);
        if (!neg) begin
            if (q > 64'h0000_0000_7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
            return {1'b0, q[31:0]};
        end
        if (q > 64'h0000_0000_8000_0000) return {1'b1, 32'h8000_0000};
        return {1'b0, (~q[31:0]) + 32'd1};
    endfunction

    // {overflow, value} for a 33-bit signed sum
    function automatic logic [32:0] sat33(input logic [32:0] v);
        if (!v[32] && v[31]) return {1'b1, 32'h7FFF_FFFF};
        if (v[32] && !v[31]) return {1'b1, 32'h8000_0000};
        return {1'b0, v[31:0]};
    endfunction

    // sign-magnitude add, {neg, mag}
    function automatic logic [64:0] sm_add(input logic an, input logic [63:0] am,
                                           input logic bn, input logic [63:0] bm);
        logic        n;
        logic [63:0] m;
        if (an == bn) begin
            n = an;
            m = am + bm;
        end else if (am >= bm) begin
            n = an;
            m = am - bm;
        end else begin
            n = bn;
            m = bm - am;
        end
        if (m == 64'd0) n = 1'b0;
        return {n, m};
    endfunction

endpackage

`default_nettype wire

/* rtl/cau_datapath.sv */
// Datapath: operand and result registers, shared 32x32 product engine,
// restoring long divider, exponent counter and output register. Uses cau_pkg.
`default_nettype none

module cau_datapath import cau_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int EXP_BITS  = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    output t_stat                    o_stat,
    input  wire logic [2:0]          i_req_type,
    input  wire logic [31:0]         i_a_real,
    input  wire logic [31:0]         i_a_imag,
    input  wire logic [31:0]         i_b_real,
    input  wire logic [31:0]         i_b_imag,
    input  wire logic [EXP_BITS:0]   i_exponent,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [31:0]              o_res_real,
    output logic [31:0]              o_res_imag,
    output logic [1:0]               o_status
);

    localparam int          DW      = 64 + FRAC_BITS;
    localparam logic [31:0] ONE_Q   = 32'd1 << FRAC_BITS;
    localparam logic [63:0] RND_ADD = (64'd1 << FRAC_BITS) - 64'd1;

    logic [2:0]        r_req;
    logic [31:0]       r_ar, r_ai, r_br, r_bi, r_rr, r_ri;
    logic [EXP_BITS:0] r_k;
    logic              r_kneg, r_ovf, r_dz;
    logic [63:0]       r_pm;
    logic              r_pneg, r_pv;
    logic [2:0]        r_ptag;
    logic              r_acc_rn, r_acc_in;
    logic [63:0]       r_acc_rm, r_acc_im, r_d;
    logic [DW-1:0]     r_dsh;
    logic [63:0]       r_rem;
    logic [32:0]       r_q;
    logic              r_big, r_nneg;
    logic              r_o_valid;
    logic [31:0]       r_o_re, r_o_im;
    logic [1:0]        r_o_st;

    function automatic logic [31:0] mag32(input logic [31:0] x);
        return x[31] ? (~x) + 32'd1 : x;
    endfunction

    function automatic logic [32:0] scale_down(input logic neg, input logic [63:0] m);
        logic [63:0] q;
        q = neg ? ((m + RND_ADD) >> FRAC_BITS) : (m >> FRAC_BITS);
        return sat_mag(neg, q);
    endfunction

    logic [31:0] xr, xi, yr, yi, m1, m2, m1m, m2m;
    logic [63:0] prod;
    logic        inv, pneg;

    always_comb begin
        case (i_cmd.mode.xsel)
            XS_RES:  begin xr = r_rr;  xi = r_ri;  end
            XS_ONE:  begin xr = ONE_Q; xi = 32'd0; end
            default: begin xr = r_ar;  xi = r_ai;  end
        endcase
        case (i_cmd.mode.ysel)
            YS_B:    begin yr = r_br; yi = r_bi; end
            YS_RES:  begin yr = r_rr; yi = r_ri; end
            default: begin yr = r_ar; yi = r_ai; end
        endcase
        case (i_cmd.step)
            PR_RR:   begin m1 = xr; m2 = yr; end
            PR_II:   begin m1 = xi; m2 = yi; end
            PR_RI:   begin m1 = xr; m2 = yi; end
            PR_IR:   begin m1 = xi; m2 = yr; end
            PR_YRR:  begin m1 = yr; m2 = yr; end
            PR_YII:  begin m1 = yi; m2 = yi; end
            default: begin m1 = 32'd0; m2 = 32'd0; end
        endcase
        m1m  = mag32(m1);
        m2m  = mag32(m2);
        prod = {32'd0, m1m} * {32'd0, m2m};
        inv  = ((i_cmd.step == PR_II) && !i_cmd.mode.conj) ||
               ((i_cmd.step == PR_RI) && i_cmd.mode.conj);
        pneg = (prod != 64'd0) && ((m1[31] ^ m2[31]) ^ inv);
    end

    logic [64:0] acc_sum;
    always_comb begin
        if (r_ptag == PR_II) acc_sum = sm_add(r_acc_rn, r_acc_rm, r_pneg, r_pm);
        else                 acc_sum = sm_add(r_acc_in, r_acc_im, r_pneg, r_pm);
    end

    logic [32:0] sd_re, sd_im;
    assign sd_re = scale_down(r_acc_rn, r_acc_rm);
    assign sd_im = scale_down(r_acc_in, r_acc_im);

    logic [63:0] rem_sh, rem_nx;
    logic        ge;
    logic [32:0] q_sh, q_fin;
    logic [33:0] q_rnd;
    logic [32:0] d_sat;
    always_comb begin
        rem_sh = {r_rem[62:0], r_dsh[DW-1]};
        ge     = rem_sh >= r_d;
        rem_nx = ge ? rem_sh - r_d : rem_sh;
        q_sh   = {r_q[31:0], ge};
        q_fin  = r_big ? {1'b1, 32'd0} : r_q;
        q_rnd  = {1'b0, q_fin} + {33'd0, (r_nneg && (r_rem != 64'd0))};
        d_sat  = sat_mag(r_nneg, {30'd0, q_rnd});
    end

    logic [32:0] s_re, s_im;
    always_comb begin
        case (t_req'(r_req))
            REQ_ADD: begin
                s_re = sat33({r_ar[31], r_ar} + {r_br[31], r_br});
                s_im = sat33({r_ai[31], r_ai} + {r_bi[31], r_bi});
            end
            REQ_SUB: begin
                s_re = sat33({r_ar[31], r_ar} - {r_br[31], r_br});
                s_im = sat33({r_ai[31], r_ai} - {r_bi[31], r_bi});
            end
            REQ_NEG: begin
                s_re = sat33(33'd0 - {r_ar[31], r_ar});
                s_im = sat33(33'd0 - {r_ai[31], r_ai});
            end
            REQ_CONJ: begin
                s_re = {1'b0, r_ar};
                s_im = sat33(33'd0 - {r_ai[31], r_ai});
            end
            default: begin
                s_re = 33'd0;
                s_im = 33'd0;
            end
        endcase
    end

    logic [EXP_BITS:0] k_in;
    assign k_in = i_exponent[EXP_BITS] ? (~i_exponent) + (EXP_BITS+1)'(1) : i_exponent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv      <= 1'b0;
            r_o_valid <= 1'b0;
            r_ovf     <= 1'b0;
            r_dz      <= 1'b0;
        end else begin
            r_pv <= (i_cmd.op == OP_PROD);
            if (i_cmd.op == OP_OUT) r_o_valid <= 1'b1;
            else if (i_ready)       r_o_valid <= 1'b0;
            if (r_pv) begin
                case (r_ptag)
                    PR_RR:  begin r_acc_rn <= r_pneg; r_acc_rm <= r_pm; end
                    PR_II:  begin r_acc_rn <= acc_sum[64]; r_acc_rm <= acc_sum[63:0]; end
                    PR_RI:  begin r_acc_in <= r_pneg; r_acc_im <= r_pm; end
                    PR_IR:  begin r_acc_in <= acc_sum[64]; r_acc_im <= acc_sum[63:0]; end
                    PR_YRR: r_d <= r_pm;
                    PR_YII: r_d <= r_d + r_pm;
                    default: ;
                endcase
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    r_req  <= i_req_type;
                    r_ar   <= i_a_real;
                    r_ai   <= i_a_imag;
                    r_br   <= i_b_real;
                    r_bi   <= i_b_imag;
                    r_k    <= k_in;
                    r_kneg <= i_exponent[EXP_BITS];
                    r_rr   <= ONE_Q;
                    r_ri   <= 32'd0;
                    r_ovf  <= 1'b0;
                    r_dz   <= 1'b0;
                end
                OP_SIMPLE: begin
                    r_rr  <= s_re[31:0];
                    r_ri  <= s_im[31:0];
                    r_ovf <= s_re[32] | s_im[32];
                end
                OP_PROD: begin
                    r_pm   <= prod;
                    r_pneg <= pneg;
                    r_ptag <= i_cmd.step;
                end
                OP_MFIN: begin
                    if (i_cmd.mode.dest_a) begin
                        r_ar <= sd_re[31:0];
                        r_ai <= sd_im[31:0];
                    end else begin
                        r_rr <= sd_re[31:0];
                        r_ri <= sd_im[31:0];
                    end
                    r_ovf <= r_ovf | sd_re[32] | sd_im[32];
                end
                OP_DZERO: begin
                    r_rr <= 32'd0;
                    r_ri <= 32'd0;
                    r_dz <= 1'b1;
                end
                OP_DINIT: begin
                    r_dsh  <= {(i_cmd.part_im ? r_acc_im : r_acc_rm), {FRAC_BITS{1'b0}}};
                    r_nneg <= i_cmd.part_im ? r_acc_in : r_acc_rn;
                    r_rem  <= 64'd0;
                    r_q    <= 33'd0;
                    r_big  <= 1'b0;
                end
                OP_DSTEP: begin
                    r_rem <= rem_nx;
                    r_dsh <= {r_dsh[DW-2:0], 1'b0};
                    if (!r_big) begin
                        r_q   <= q_sh;
                        r_big <= q_sh[32];
                    end
                end
                OP_DFIN: begin
                    if (i_cmd.part_im) r_ri <= d_sat[31:0];
                    else               r_rr <= d_sat[31:0];
                    r_ovf <= r_ovf | d_sat[32];
                end
                OP_KSHIFT: r_k <= r_k >> 1;
                OP_OUT: begin
                    r_o_re    <= r_rr;
                    r_o_im    <= r_ri;
                    r_o_st    <= r_dz ? ST_DZ : (r_ovf ? ST_OVF : ST_OK);
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_stat.req      = t_req'(r_req);
        o_stat.k_zero   = (r_k == '0);
        o_stat.k_lsb    = r_k[0];
        o_stat.k_one    = (r_k == (EXP_BITS+1)'(1));
        o_stat.k_neg    = r_kneg;
        o_stat.d_zero   = (r_d == 64'd0);
        o_stat.out_free = !r_o_valid || i_ready;
    end

    assign o_valid    = r_o_valid;
    assign o_res_real = r_o_re;
    assign o_res_imag = r_o_im;
    assign o_status   = r_o_st;

endmodule

`default_nettype wire

/* rtl/cau_ctrl.sv */
// Controller: sequences load, products, long division, power steps and output.
// Uses cau_pkg; drives cau_datapath through t_cmd and reads t_stat.
`default_nettype none

module cau_ctrl import cau_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    localparam int DIV_STEPS = 64 + FRAC_BITS;
    localparam int CW        = $clog2(DIV_STEPS);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    t_mode         r_mode, n_mode;
    t_state        r_ret, n_ret;
    logic          r_dim, n_dim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_mode  <= M_MUL;
            r_ret   <= S_FIN;
            r_dim   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_mode  <= n_mode;
            r_ret   <= n_ret;
            r_dim   <= n_dim;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_mode        = r_mode;
        n_ret         = r_ret;
        n_dim         = r_dim;
        o_in_ready    = 1'b0;
        o_cmd.op      = OP_NOP;
        o_cmd.step    = r_cnt[2:0];
        o_cmd.mode    = r_mode;
        o_cmd.part_im = r_dim;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_cnt = '0;
                unique case (i_stat.req)
                    REQ_MUL: begin
                        n_mode  = M_MUL;
                        n_ret   = S_FIN;
                        n_state = S_MUL;
                    end
                    REQ_DIV: begin
                        n_mode  = M_DIV;
                        n_state = S_MUL;
                    end
                    REQ_POW: n_state = S_PWTEST;
                    default: begin
                        o_cmd.op = OP_SIMPLE;
                        n_state  = S_FIN;
                    end
                endcase
            end
            S_MUL: begin
                o_cmd.op = OP_PROD;
                if (r_cnt == CW'(r_mode.conj ? CDIV_LAST : CMUL_LAST)) begin
                    n_cnt   = '0;
                    n_state = S_MWAIT;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_MWAIT: n_state = r_mode.conj ? S_DCHK : S_MFIN;
            S_MFIN: begin
                o_cmd.op = OP_MFIN;
                n_state  = r_ret;
            end
            S_DCHK: begin
                if (i_stat.d_zero) begin
                    o_cmd.op = OP_DZERO;
                    n_state  = S_FIN;
                end else begin
                    n_dim   = 1'b0;
                    n_state = S_DINIT;
                end
            end
            S_DINIT: begin
                o_cmd.op = OP_DINIT;
                n_cnt    = '0;
                n_state  = S_DRUN;
            end
            S_DRUN: begin
                o_cmd.op = OP_DSTEP;
                if (r_cnt == CW'(DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DFIN;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_DFIN: begin
                o_cmd.op = OP_DFIN;
                if (r_dim) begin
                    n_state = S_FIN;
                end else begin
                    n_dim   = 1'b1;
                    n_state = S_DINIT;
                end
            end
            S_PWTEST: begin
                n_cnt = '0;
                if (i_stat.k_zero) begin
                    if (i_stat.k_neg) begin
                        n_mode  = M_RECIP;
                        n_state = S_MUL;
                    end else begin
                        n_state = S_FIN;
                    end
                end else if (i_stat.k_lsb) begin
                    n_mode  = M_RSTEP;
                    n_ret   = S_PWSQ;
                    n_state = S_MUL;
                end else begin
                    n_state = S_PWSQ;
                end
            end
            S_PWSQ: begin
                o_cmd.op = OP_KSHIFT;
                n_cnt    = '0;
                if (i_stat.k_one) begin
                    if (i_stat.k_neg) begin
                        n_mode  = M_RECIP;
                        n_state = S_MUL;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_mode  = M_SQ;
                    n_ret   = S_PWTEST;
                    n_state = S_MUL;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/complex_arith_unit.sv */
// Complex Q16.16 arithmetic unit: add, sub, mul, div, negate, conjugate, power.
// Multiply runs the shared product engine; divide adds a zero check and the
// one-bit-a-cycle divider for the real and then the imaginary part.
// Power: per exponent bit a test, an optional multiply, a shift and, while bits remain,
// a squaring multiply, plus a divide for a negative exponent. One item in flight; the
// next is taken in the cycle after the output register loads. Reset (synchronous,
// active low) returns the controller to idle and empties the output.
`default_nettype none

module complex_arith_unit import cau_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int EXP_BITS  = 8,
    localparam int IN_W = ((128 + EXP_BITS + 1 + 7) / 8) * 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // a_real, a_imag, b_real, b_imag, exponent, zero padding
    input  wire logic [IN_W-1:0] i_s_axis_tdata,
    // req_type
    input  wire logic [2:0]      i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  wire logic            i_m_axis_tready,
    // res_real, res_imag
    output logic [63:0]          o_m_axis_tdata,
    // status
    output logic [1:0]           o_m_axis_tuser
);

    t_cmd  cmd;
    t_stat stat;

    cau_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cau_datapath #(.FRAC_BITS(FRAC_BITS), .EXP_BITS(EXP_BITS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_req_type (i_s_axis_tuser),
        .i_a_real   (i_s_axis_tdata[31:0]),
        .i_a_imag   (i_s_axis_tdata[63:32]),
        .i_b_real   (i_s_axis_tdata[95:64]),
        .i_b_imag   (i_s_axis_tdata[127:96]),
        .i_exponent (i_s_axis_tdata[128 +: EXP_BITS + 1]),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_res_real (o_m_axis_tdata[31:0]),
        .o_res_imag (o_m_axis_tdata[63:32]),
        .o_status   (o_m_axis_tuser)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken while an item is in progress");

    a_dz_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == ST_DZ)) |-> (o_m_axis_tdata == 64'd0))
        else $error("division by zero with nonzero result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((o_m_axis_tuser == ST_OK) || (o_m_axis_tuser == ST_DZ) ||
                             (o_m_axis_tuser == ST_OVF)))
        else $error("bad status code");

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for complex_arith_unit, uses cau_pkg: directed table then
// random requests, each checked against a table value or a fixed-point predictor.
`default_nettype none

module tb_top;
    import cau_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam int EXPB = 8;
    localparam int IN_W = ((128 + EXPB + 1 + 7) / 8) * 8;
    localparam int N_RAND = 450;
    localparam int WD_LIMIT = 20000;
    localparam logic [31:0] QONE = 32'h0001_0000;
    localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NMAX = 32'h8000_0000;

    typedef struct {
        logic [2:0]  req;
        logic [31:0] ar, ai, br, bi;
        logic [8:0]  ex;
        logic        known;
        logic [31:0] rr, ri;
        logic [1:0]  st;
    } t_item;

    typedef struct {
        logic [31:0] rr, ri;
        logic [1:0]  st;
    } t_res;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_s_axis_tvalid;
    logic            o_s_axis_tready;
    logic [IN_W-1:0] i_s_axis_tdata;
    logic [2:0]      i_s_axis_tuser;
    logic            o_m_axis_tvalid;
    logic            i_m_axis_tready;
    logic [63:0]     o_m_axis_tdata;
    logic [1:0]      o_m_axis_tuser;

    complex_arith_unit dut (.*);

    t_res   expected_q[$];
    t_item  table_q[$];
    int     mismatches = 0;
    int     idle_cycles = 0;
    bit     feed_done = 0;
    bit     hold_off = 0;
    bit     ovf_f, dz_f;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [63:0] absv(input longint x);
        return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    function automatic logic [31:0] sat_sm(input bit neg, input logic [63:0] q);
        if (!neg) begin
            if (q > 64'(PMAX)) begin ovf_f = 1; return PMAX; end
            return q[31:0];
        end
        if (q > 64'(NMAX)) begin ovf_f = 1; return NMAX; end
        return 32'(-q);
    endfunction

    function automatic logic [31:0] sat_long(input longint v);
        return sat_sm(v < 0, absv(v));
    endfunction

    // signed magnitude {neg, mag}
    function automatic logic [64:0] smul(input longint x, input longint y);
        logic [63:0] m;
        m = absv(x) * absv(y);
        return {m != 0 && ((x < 0) != (y < 0)), m};
    endfunction

    function automatic logic [64:0] sneg(input logic [64:0] a);
        return {a[63:0] != 0 && !a[64], a[63:0]};
    endfunction

    function automatic logic [64:0] sadd(input logic [64:0] a, input logic [64:0] b);
        bit n;
        logic [63:0] m;
        if (a[64] == b[64]) begin n = a[64]; m = a[63:0] + b[63:0]; end
        else if (a[63:0] >= b[63:0]) begin n = a[64]; m = a[63:0] - b[63:0]; end
        else begin n = b[64]; m = b[63:0] - a[63:0]; end
        if (m == 0) n = 0;
        return {n, m};
    endfunction

    function automatic logic [31:0] shrink(input logic [64:0] s);
        logic [63:0] q;
        q = s[64] ? (s[63:0] + 64'(QONE) - 1) >> FRAC : s[63:0] >> FRAC;
        return sat_sm(s[64], q);
    endfunction

    function automatic logic [31:0] floor_div(input logic [64:0] n, input logic [63:0] d);
        logic [127:0] num;
        logic [63:0]  rem, q;
        bit big, qb;
        num = {64'd0, n[63:0]} << FRAC;
        rem = 0; q = 0; big = 0;
        for (int i = 127; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            qb = 0;
            if (rem >= d) begin rem -= d; qb = 1; end
            if (!big) begin
                q = {q[62:0], qb};
                if (q > 64'hFFFF_FFFF) big = 1;
            end
        end
        if (big) q = 64'h1_0000_0000;
        if (n[64] && rem != 0) q += 1;
        return sat_sm(n[64], q);
    endfunction

    function automatic void cx_mul(input longint xr, xi, yr, yi, output longint zr, zi);
        zr = longint'($signed(shrink(sadd(smul(xr, yr), sneg(smul(xi, yi))))));
        zi = longint'($signed(shrink(sadd(smul(xr, yi), smul(xi, yr)))));
    endfunction

    function automatic void cx_div(input longint xr, xi, yr, yi, output longint zr, zi);
        logic [63:0] d;
        d = absv(yr) * absv(yr) + absv(yi) * absv(yi);
        zr = 0; zi = 0;
        if (d == 0) begin dz_f = 1; return; end
        zr = longint'($signed(floor_div(sadd(smul(xr, yr), smul(xi, yi)), d)));
        zi = longint'($signed(floor_div(sadd(smul(xi, yr), sneg(smul(xr, yi))), d)));
    endfunction

    function automatic t_res compute_result(input t_item it);
        t_res   r;
        longint ar, ai, br, bi, zr, zi, pr, pi, sr, si, tr, ti;
        int     k;
        bit     negk;
        ar = longint'($signed(it.ar)); ai = longint'($signed(it.ai));
        br = longint'($signed(it.br)); bi = longint'($signed(it.bi));
        ovf_f = 0; dz_f = 0; zr = 0; zi = 0;
        case (it.req)
            REQ_ADD: begin
                zr = longint'($signed(sat_long(ar + br)));
                zi = longint'($signed(sat_long(ai + bi)));
            end
            REQ_SUB: begin
                zr = longint'($signed(sat_long(ar - br)));
                zi = longint'($signed(sat_long(ai - bi)));
            end
            REQ_MUL: cx_mul(ar, ai, br, bi, zr, zi);
            REQ_DIV: cx_div(ar, ai, br, bi, zr, zi);
            REQ_NEG: begin
                zr = longint'($signed(sat_long(-ar)));
                zi = longint'($signed(sat_long(-ai)));
            end
            REQ_CONJ: begin
                zr = ar;
                zi = longint'($signed(sat_long(-ai)));
            end
            REQ_POW: begin
                negk = it.ex[8];
                k = negk ? 512 - int'(it.ex) : int'(it.ex);
                pr = QONE; pi = 0; sr = ar; si = ai;
                while (k != 0) begin
                    if (k[0]) begin cx_mul(pr, pi, sr, si, tr, ti); pr = tr; pi = ti; end
                    k = k >> 1;
                    if (k != 0) begin cx_mul(sr, si, sr, si, tr, ti); sr = tr; si = ti; end
                end
                if (negk) cx_div(QONE, 0, pr, pi, zr, zi);
                else begin zr = pr; zi = pi; end
            end
            default: ;
        endcase
        r.rr = zr[31:0];
        r.ri = zi[31:0];
        r.st = dz_f ? ST_DZ : (ovf_f ? ST_OVF : ST_OK);
        return r;
    endfunction

    function automatic t_item row(input logic [2:0] rq, input logic [31:0] ar, ai, br, bi,
                                  input logic [8:0] ex, input bit kn = 0,
                                  input logic [31:0] rr = 0, ri = 0, input logic [1:0] st = 0);
        t_item it;
        it.req = rq; it.ar = ar; it.ai = ai; it.br = br; it.bi = bi; it.ex = ex;
        it.known = kn; it.rr = rr; it.ri = ri; it.st = st;
        return it;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            2: return 32'($signed($urandom_range(0, 8'hFF) << 12)) - 32'h0008_0000;
            3: return $urandom_range(0, 1) ? PMAX : NMAX;
            4: return 32'($urandom_range(0, 3)) << FRAC;
            default: return 32'($signed(16'($urandom()))) <<< $urandom_range(0, 10);
        endcase
    endfunction

    task automatic send_item(input t_item it);
        while ($urandom_range(0, 3) == 0 && !hold_off) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : 1) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= it.req;
        i_s_axis_tdata  <= IN_W'({it.ex, it.bi, it.br, it.ai, it.ar});
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (it.known) expected_q.push_back('{it.rr, it.ri, it.st});
        else expected_q.push_back(compute_result(it));
    endtask

    initial begin
        t_item it;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        table_q.push_back(row(REQ_ADD, QONE, 0, QONE, QONE, 0, 1, 32'h0002_0000, QONE, ST_OK));
        table_q.push_back(row(REQ_ADD, PMAX, NMAX, 1, 32'hFFFF_FFFF, 0, 1, PMAX, NMAX, ST_OVF));
        table_q.push_back(row(REQ_SUB, NMAX, PMAX, 1, 32'hFFFF_FFFF, 0, 1, NMAX, PMAX, ST_OVF));
        table_q.push_back(row(REQ_SUB, 5, 7, 5, 7, 0, 1, 0, 0, ST_OK));
        table_q.push_back(row(REQ_NEG, NMAX, 3, 0, 0, 0, 1, PMAX, 32'hFFFF_FFFD, ST_OVF));
        table_q.push_back(row(REQ_CONJ, NMAX, NMAX, 0, 0, 0, 1, NMAX, PMAX, ST_OVF));
        table_q.push_back(row(REQ_CONJ, PMAX, PMAX, 0, 0, 0, 1, PMAX, 32'h8000_0001, ST_OK));
        table_q.push_back(row(REQ_MUL, QONE, QONE, QONE, 32'hFFFF_0000, 0, 1,
                              32'h0002_0000, 0, ST_OK));
        table_q.push_back(row(REQ_MUL, PMAX, PMAX, PMAX, PMAX, 0));
        table_q.push_back(row(REQ_MUL, NMAX, NMAX, NMAX, PMAX, 0));
        table_q.push_back(row(REQ_MUL, 32'hFFFF_FFFF, 0, 1, 0, 0));
        table_q.push_back(row(REQ_DIV, QONE, QONE, 0, 0, 0, 1, 0, 0, ST_DZ));
        table_q.push_back(row(REQ_DIV, 32'h0004_0000, 0, 32'h0002_0000, 0, 0, 1,
                              32'h0002_0000, 0, ST_OK));
        table_q.push_back(row(REQ_DIV, PMAX, NMAX, 1, 0, 0));
        table_q.push_back(row(REQ_DIV, NMAX, PMAX, NMAX, NMAX, 0));
        table_q.push_back(row(REQ_DIV, 32'hFFFF_FFFF, 1, 3, 0, 0));
        table_q.push_back(row(REQ_POW, 32'h1234_5678, 9, 0, 0, 9'd0, 1, QONE, 0, ST_OK));
        table_q.push_back(row(REQ_POW, QONE, QONE, 0, 0, 9'd255));
        table_q.push_back(row(REQ_POW, 32'h0000_F000, 32'h0000_1000, 0, 0, 9'h100));
        table_q.push_back(row(REQ_POW, 0, 0, 0, 0, 9'h1FF, 1, 0, 0, ST_DZ));
        table_q.push_back(row(REQ_POW, 32'h0002_0000, 0, 0, 0, 9'h1FE));
        table_q.push_back(row(REQ_POW, 32'h0000_8000, 32'h0000_8000, 0, 0, 9'd3));
        table_q.push_back(row(3'd7, PMAX, NMAX, PMAX, NMAX, 9'h1FF, 1, 0, 0, ST_OK));

        foreach (table_q[n]) send_item(table_q[n]);

        for (int n = 0; n < N_RAND; n++) begin
            it = row(3'($urandom_range(0, 7)), rand_operand(), rand_operand(),
                     rand_operand(), rand_operand(), 9'($urandom()));
            if (it.req == REQ_POW && $urandom_range(0, 3) != 0) begin
                it.ex = 9'($signed($urandom_range(0, 16)) - 8);
                it.ar = 32'($signed(18'($urandom())));
                it.ai = 32'($signed(18'($urandom())));
            end
            if (it.req == REQ_DIV && $urandom_range(0, 7) == 0) begin
                it.br = 0; it.bi = 0;
            end
            send_item(it);
        end
        i_s_axis_tvalid <= 1'b0;
        feed_done = 1;
    end

    // receiver: random stalls, one long hold-off early on
    initial begin
        i_m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        repeat (40) begin
            i_m_axis_tready <= 1'($urandom_range(0, 1));
            @(posedge i_clk);
        end
        hold_off = 1;
        i_m_axis_tready <= 1'b0;
        repeat (600) @(posedge i_clk);
        hold_off = 0;
        forever begin
            if ($urandom_range(0, 19) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 60)) @(posedge i_clk);
            end else if ($urandom_range(0, 3) == 0) begin
                i_m_axis_tready <= 1'($urandom_range(0, 1));
                @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h %h", o_m_axis_tdata,
                                               o_m_axis_tuser);
            end else begin
                e = expected_q.pop_front();
                if (o_m_axis_tdata !== {e.ri, e.rr} || o_m_axis_tuser !== e.st) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected re %h im %h st %0d, got re %h im %h st %0d",
                                 e.rr, e.ri, e.st, o_m_axis_tdata[31:0],
                                 o_m_axis_tdata[63:32], o_m_axis_tuser);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (feed_done);
        while (expected_q.size() != 0 && idle_cycles < WD_LIMIT) @(posedge i_clk);
        if (idle_cycles >= WD_LIMIT) begin
            $display("FAILURE");
        end else begin
            repeat (400) @(posedge i_clk);
            if (mismatches == 0 && expected_q.size() == 0) $display("SUCCESS");
            else $display("FAILURE");
        end
        $finish;
    end

    initial begin
        @(posedge i_rst_n);
        wait (idle_cycles >= WD_LIMIT && !feed_done);
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
rtl/cau_pkg.sv
rtl/cau_datapath.sv
rtl/cau_ctrl.sv
rtl/complex_arith_unit.sv
bench/tb_top.sv
